// ----- rtl/stc_pkg.sv -----
// shared types, constants and helpers for the shade threshold controller
`timescale 1ns / 1ps

package stc_pkg;

    // field widths
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned ADC_W   = 10;
    localparam int unsigned ECHO_W  = 16;
    localparam int unsigned LEVEL_W = 16;
    localparam int unsigned TEMP_W  = 9;
    localparam int unsigned LIGHT_W = 8;
    localparam int unsigned DIST_W  = 14;
    localparam int unsigned STOP_W  = 10;

    // packed bus widths
    localparam int unsigned S_DATA_W = 48;
    localparam int unsigned M_DATA_W = 40;

    // request kinds carried on tuser
    localparam logic OP_SERIAL   = 1'b0;
    localparam logic OP_EVALUATE = 1'b1;

    // command and digit characters
    localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_ONE    = 8'h31;
    localparam logic [BYTE_W-1:0] CHAR_TWO    = 8'h32;
    localparam logic [BYTE_W-1:0] CHAR_THREE  = 8'h33;
    localparam logic [BYTE_W-1:0] CHAR_SEVEN  = 8'h37;
    localparam logic [BYTE_W-1:0] CHAR_EIGHT  = 8'h38;

    // reset values
    localparam logic [LEVEL_W-1:0] TEMP_CLOSE_RST  = 16'd24;
    localparam logic [LEVEL_W-1:0] TEMP_OPEN_RST   = 16'd16;
    localparam logic [LEVEL_W-1:0] LIGHT_CLOSE_RST = 16'd60;
    localparam logic [LEVEL_W-1:0] LIGHT_OPEN_RST  = 16'd16;
    localparam logic [LEVEL_W-1:0] MAN_DIST_RST    = 16'd20;
    localparam logic [LEVEL_W-1:0] MAN_DIST_ONE    = 16'd5;
    localparam logic [LEVEL_W-1:0] MAN_DIST_TWO    = 16'd10;
    localparam logic [STOP_W-1:0]  CLOSE_STOP_RST  = 10'd5;

    // conversion factors (adc * factor / 1024)
    localparam logic [8:0] TEMP_SCALE  = 9'd500;
    localparam logic [7:0] LIGHT_SCALE = 8'd150;
    localparam logic [TEMP_W-1:0] TEMP_OFFSET = 9'd50;
    localparam int unsigned SCALE_SHIFT = 10;

    // thresholds and mode shared by parser and evaluator
    typedef struct packed {
        logic [LEVEL_W-1:0] temp_close;
        logic [LEVEL_W-1:0] temp_open;
        logic [LEVEL_W-1:0] light_close;
        logic [LEVEL_W-1:0] light_open;
        logic [LEVEL_W-1:0] manual_dist;
        logic               manual;
    } levels_t;

    // one result item
    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic [LIGHT_W-1:0] light_level;
        logic [TEMP_W-1:0]  temperature;
        logic               moving_pulse;
        logic               green_on;
        logic               red_on;
    } result_t;

    // sign extend a 16-bit level for exact compare
    function automatic logic signed [LEVEL_W+1:0] sx_level(input logic [LEVEL_W-1:0] v);
        sx_level = {{2{v[LEVEL_W-1]}}, v};
    endfunction

endpackage

// ----- rtl/stc_parser.sv -----
// serial command parser holding thresholds, manual distance and mode
`timescale 1ns / 1ps

module stc_parser (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         step,          // serial byte being processed
    input  logic [stc_pkg::BYTE_W-1:0]   rx_byte,
    input  logic [stc_pkg::DIST_W-1:0]   last_distance,
    output stc_pkg::levels_t             levels
);

    typedef enum logic [3:0] {
        PEND_NONE   = 4'b0001,
        PEND_THRESH = 4'b0010,
        PEND_DIST   = 4'b0100,
        PEND_MANUAL = 4'b1000
    } pend_t;

    localparam logic [3:0] CNT_TEMP_CLOSE  = 4'd2;
    localparam logic [3:0] CNT_TEMP_OPEN   = 4'd4;
    localparam logic [3:0] CNT_LIGHT_CLOSE = 4'd6;
    localparam logic [3:0] CNT_LIGHT_OPEN  = 4'd8;
    localparam logic [3:0] CNT_DIST_DONE   = 4'd3;

    stc_pkg::levels_t               levels_reg, levels_next;
    pend_t                          pend_reg, pend_next;
    logic [3:0]                     count_reg, count_next;
    logic [stc_pkg::LEVEL_W-1:0]    held_reg, held_next;

    logic [stc_pkg::LEVEL_W-1:0]    digit;
    logic [stc_pkg::LEVEL_W-1:0]    held_base;
    logic [stc_pkg::LEVEL_W-1:0]    pushed;
    logic [3:0]                     count_inc;

    // decimal accumulate, wrapping at 16 bits
    always_comb begin
        digit     = {8'd0, rx_byte} - {8'd0, stc_pkg::CHAR_ZERO};
        held_base = (pend_reg == PEND_THRESH && !count_reg[0]) ? '0 : held_reg;
        pushed    = (held_base << 3) + (held_base << 1) + digit;
        count_inc = count_reg + 4'd1;
    end

    // command sequencing
    always_comb begin
        levels_next = levels_reg;
        pend_next   = pend_reg;
        count_next  = count_reg;
        held_next   = held_reg;
        if (step) begin
            case (pend_reg)
                PEND_THRESH: begin
                    held_next  = pushed;
                    count_next = count_inc;
                    case (count_inc)
                        CNT_TEMP_CLOSE:  levels_next.temp_close  = pushed;
                        CNT_TEMP_OPEN:   levels_next.temp_open   = pushed;
                        CNT_LIGHT_CLOSE: levels_next.light_close = pushed;
                        CNT_LIGHT_OPEN: begin
                            levels_next.light_open = pushed;
                            pend_next  = PEND_NONE;
                            count_next = '0;
                        end
                        default: ;
                    endcase
                end
                PEND_DIST: begin
                    held_next  = pushed;
                    count_next = count_inc;
                    if (count_inc >= CNT_DIST_DONE) begin
                        levels_next.manual_dist = pushed;
                        pend_next  = PEND_NONE;
                        count_next = '0;
                    end
                end
                PEND_MANUAL: begin
                    levels_next.manual = (rx_byte != '0);
                    if (rx_byte == 8'd1) begin
                        levels_next.manual_dist = {2'b00, last_distance};
                    end
                    pend_next  = PEND_NONE;
                    count_next = '0;
                end
                default: begin
                    case (rx_byte)
                        stc_pkg::CHAR_ONE: begin
                            levels_next.manual      = 1'b1;
                            levels_next.manual_dist = stc_pkg::MAN_DIST_ONE;
                        end
                        stc_pkg::CHAR_TWO: begin
                            levels_next.manual      = 1'b1;
                            levels_next.manual_dist = stc_pkg::MAN_DIST_TWO;
                        end
                        stc_pkg::CHAR_THREE: begin
                            levels_next.manual = 1'b0;
                            pend_next  = PEND_THRESH;
                            count_next = '0;
                            held_next  = '0;
                        end
                        stc_pkg::CHAR_SEVEN: begin
                            levels_next.manual = 1'b1;
                            pend_next  = PEND_DIST;
                            count_next = '0;
                            held_next  = '0;
                        end
                        stc_pkg::CHAR_EIGHT: begin
                            pend_next  = PEND_MANUAL;
                            count_next = '0;
                        end
                        default: ;
                    endcase
                end
            endcase
        end
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            levels_reg.temp_close  <= stc_pkg::TEMP_CLOSE_RST;
            levels_reg.temp_open   <= stc_pkg::TEMP_OPEN_RST;
            levels_reg.light_close <= stc_pkg::LIGHT_CLOSE_RST;
            levels_reg.light_open  <= stc_pkg::LIGHT_OPEN_RST;
            levels_reg.manual_dist <= stc_pkg::MAN_DIST_RST;
            levels_reg.manual      <= 1'b0;
            pend_reg  <= PEND_NONE;
            count_reg <= '0;
            held_reg  <= '0;
        end else begin
            levels_reg <= levels_next;
            pend_reg   <= pend_next;
            count_reg  <= count_next;
            held_reg   <= held_next;
        end
    end

    assign levels = levels_reg;

endmodule

// ----- rtl/stc_eval.sv -----
// sensor conversion and close/open rule with held indicator state
`timescale 1ns / 1ps

module stc_eval (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          step,         // request being processed
    input  logic                          evaluate,     // request is an evaluation
    input  logic [stc_pkg::ADC_W-1:0]     temp_adc,
    input  logic [stc_pkg::ADC_W-1:0]     light_adc,
    input  logic [stc_pkg::ECHO_W-1:0]    echo_count,
    input  logic [stc_pkg::STOP_W-1:0]    close_stop_distance,
    input  stc_pkg::levels_t              levels,
    output stc_pkg::result_t              result,
    output logic [stc_pkg::DIST_W-1:0]    last_distance
);

    logic                           red_reg, red_next;
    logic                           green_reg, green_next;
    logic [stc_pkg::DIST_W-1:0]     last_dist_reg, last_dist_next;

    logic [18:0]                    temp_prod;
    logic [17:0]                    light_prod;
    logic [stc_pkg::TEMP_W-1:0]     temp_raw;
    logic [stc_pkg::TEMP_W-1:0]     temp_val;
    logic [stc_pkg::LIGHT_W-1:0]    light_val;
    logic [stc_pkg::DIST_W-1:0]     dist_val;
    logic signed [17:0]             t_s, l_s, d_s, dm_s;
    logic                           close_hit, open_hit;
    logic                           pulse;

    // fixed point conversions
    always_comb begin
        temp_prod  = 19'(temp_adc) * 19'(stc_pkg::TEMP_SCALE);
        light_prod = 18'(light_adc) * 18'(stc_pkg::LIGHT_SCALE);
        temp_raw   = temp_prod[stc_pkg::SCALE_SHIFT +: stc_pkg::TEMP_W];
        temp_val   = (temp_raw >= stc_pkg::TEMP_OFFSET) ? temp_raw - stc_pkg::TEMP_OFFSET : '0;
        light_val  = light_prod[stc_pkg::SCALE_SHIFT +: stc_pkg::LIGHT_W];
        dist_val   = echo_count[stc_pkg::ECHO_W-1:2];
    end

    // close/open decision on signed levels
    always_comb begin
        t_s  = signed'({9'd0, temp_val});
        l_s  = signed'({10'd0, light_val});
        d_s  = signed'({4'd0, dist_val});
        dm_s = stc_pkg::sx_level(levels.manual_dist);
        close_hit = (!levels.manual &&
                     (l_s >= stc_pkg::sx_level(levels.light_close) ||
                      t_s >= stc_pkg::sx_level(levels.temp_close))) ||
                    (levels.manual && d_s > dm_s + 18'sd1);
        open_hit  = (!levels.manual &&
                     (l_s <= stc_pkg::sx_level(levels.light_open) ||
                      t_s <= stc_pkg::sx_level(levels.temp_open))) ||
                    (levels.manual && d_s < dm_s - 18'sd1);
    end

    // indicator update
    always_comb begin
        red_next       = red_reg;
        green_next     = green_reg;
        last_dist_next = last_dist_reg;
        pulse          = 1'b0;
        if (evaluate) begin
            last_dist_next = dist_val;
            if (close_hit) begin
                red_next   = 1'b1;
                green_next = 1'b0;
                pulse      = dist_val > {4'd0, close_stop_distance};
            end else if (open_hit) begin
                red_next   = 1'b0;
                green_next = 1'b1;
                pulse      = d_s < dm_s;
            end
        end
    end

    // held state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_reg       <= 1'b0;
            green_reg     <= 1'b0;
            last_dist_reg <= '0;
        end else if (step) begin
            red_reg       <= red_next;
            green_reg     <= green_next;
            last_dist_reg <= last_dist_next;
        end
    end

    // result of this request
    always_comb begin
        result.red_on       = red_next;
        result.green_on     = green_next;
        result.moving_pulse = pulse;
        result.temperature  = evaluate ? temp_val : '0;
        result.light_level  = evaluate ? light_val : '0;
        result.distance     = evaluate ? dist_val : '0;
    end

    assign last_distance = last_dist_reg;

endmodule

// ----- rtl/shade_threshold_controller.sv -----
// top level of the shade threshold controller
`timescale 1ns / 1ps

// Takes one request per clock on the s_ stream and gives one result per
// request on the m_ stream, passing through the input register and then the
// result register: the conversion, threshold compare and command decode run
// in a single pass between the two registers. Full rate holds as
// long as m_tready stays high; a stalled result register holds the input
// register too, and s_tready drops once both are full. A serial request
// (tuser 0) feeds the command parser and returns the held red/green state
// with the other fields zero; an evaluate request (tuser 1) converts the
// readings, applies the close/open rule and updates the held indicators.
// Write close_stop_distance only while no request is in flight.

module shade_threshold_controller (
    input  logic                              aclk,
    input  logic                              aresetn,
    // request in
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [stc_pkg::S_DATA_W-1:0]      s_tdata,   // rx_byte, temp_adc, light_adc, echo_count
    input  logic                              s_tuser,   // operation
    // result out
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [stc_pkg::M_DATA_W-1:0]      m_tdata,   // red_on, green_on, moving_pulse,
                                                         // temperature, light_level, distance
    // close stop distance write
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [stc_pkg::STOP_W-1:0]        cfg_data
);

    logic                           in_valid_reg, in_valid_next;
    logic                           in_op_reg;
    logic [stc_pkg::BYTE_W-1:0]     in_byte_reg;
    logic [stc_pkg::ADC_W-1:0]      in_temp_reg;
    logic [stc_pkg::ADC_W-1:0]      in_light_reg;
    logic [stc_pkg::ECHO_W-1:0]     in_echo_reg;

    logic                           out_valid_reg, out_valid_next;
    stc_pkg::result_t               out_data_reg;

    logic [stc_pkg::STOP_W-1:0]     stop_dist_reg;

    logic                           out_free;
    logic                           advance;
    logic                           take;
    stc_pkg::levels_t               levels;
    stc_pkg::result_t               result;
    logic [stc_pkg::DIST_W-1:0]     last_distance;

    // handshake
    assign out_free  = !out_valid_reg || m_tready;
    assign advance   = in_valid_reg && out_free;
    assign s_tready  = !in_valid_reg || out_free;
    assign take      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            stop_dist_reg <= stc_pkg::CLOSE_STOP_RST;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready) begin
                stop_dist_reg <= cfg_data;
            end
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (take) begin
            in_op_reg    <= s_tuser;
            in_byte_reg  <= s_tdata[7:0];
            in_temp_reg  <= s_tdata[17:8];
            in_light_reg <= s_tdata[27:18];
            in_echo_reg  <= s_tdata[43:28];
        end
    end

    // command parser
    stc_parser u_parser (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step          (advance && in_op_reg == stc_pkg::OP_SERIAL),
        .rx_byte       (in_byte_reg),
        .last_distance (last_distance),
        .levels        (levels)
    );

    // evaluator
    stc_eval u_eval (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .step                (advance),
        .evaluate            (in_op_reg == stc_pkg::OP_EVALUATE),
        .temp_adc            (in_temp_reg),
        .light_adc           (in_light_reg),
        .echo_count          (in_echo_reg),
        .close_stop_distance (stop_dist_reg),
        .levels              (levels),
        .result              (result),
        .last_distance       (last_distance)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_data_reg};

endmodule
